[design/bil_pkg.sv]
// Shared constants, codes and types of the bounded integer list engine.
package bil_pkg;

    localparam int CAPACITY   = 16;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int DATA_W     = 32;
    localparam int KIND_W     = 2;
    localparam int STAT_W     = 2;
    localparam int PORT_IDX_W = 4;
    localparam int PORT_CNT_W = 5;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_kind K_SEARCH = 2'd0;
    localparam t_kind K_MODIFY = 2'd1;
    localparam t_kind K_APPEND = 2'd2;
    localparam t_kind K_REMOVE = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_RANGE     = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    // One access to the entry store: one read and one write per cycle.
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
    } t_mem_req;

    // Result of one request as the sequencer finishes it.
    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  found;
        logic [DATA_W-1:0] old;
        logic [CNT_W-1:0]  cnt;
    } t_result;

endpackage

[design/bil_store.sv]
// Entry store: one write port and one registered read port.
module bil_store (
    input  logic                          i_clk,
    input  bil_pkg::t_mem_req             i_req,
    output logic [bil_pkg::DATA_W-1:0]    o_rd_data
);

    logic [bil_pkg::DATA_W-1:0] r_mem [bil_pkg::CAPACITY];
    logic [bil_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/bil_seq.sv]
// Request sequencer: walks the store with one shared compare and holds the fill count.
module bil_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  bil_pkg::t_kind                    i_kind,
    input  logic [bil_pkg::DATA_W-1:0]        i_value,
    input  logic [bil_pkg::PORT_IDX_W-1:0]    i_index,
    input  logic [bil_pkg::DATA_W-1:0]        i_rd_data,
    output logic                              o_busy,
    output bil_pkg::t_mem_req                 o_mem,
    output logic                              o_fin,
    output bil_pkg::t_result                  o_res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_RGET  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;

    logic [2:0]                  r_state, n_state;
    logic [bil_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [bil_pkg::IDX_W-1:0]   r_ptr, n_ptr;
    logic [bil_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [bil_pkg::DATA_W-1:0]  r_val, n_val;
    logic [bil_pkg::DATA_W-1:0]  r_old, n_old;

    logic [bil_pkg::CNT_W-1:0]   in_idx_ext;
    logic [bil_pkg::CNT_W-1:0]   idx_ext;
    logic [bil_pkg::CNT_W-1:0]   ptr_ext;
    logic                        hit;

    assign in_idx_ext = bil_pkg::CNT_W'(i_index);
    assign idx_ext    = bil_pkg::CNT_W'(r_idx);
    assign ptr_ext    = bil_pkg::CNT_W'(r_ptr);
    // The one compare unit, shared by every step of a search.
    assign hit        = (i_rd_data == r_val);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ptr   = r_ptr;
        n_idx   = r_idx;
        n_val   = r_val;
        n_old   = r_old;
        o_mem   = '0;
        o_fin   = 1'b0;
        o_res   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_val = i_value;
                    n_idx = bil_pkg::IDX_W'(i_index);
                    unique case (i_kind)
                        bil_pkg::K_SEARCH: begin
                            if (r_cnt == '0) begin
                                o_fin        = 1'b1;
                                o_res.status = bil_pkg::ST_NOT_FOUND;
                            end else begin
                                o_mem.rd_en   = 1'b1;
                                o_mem.rd_addr = '0;
                                n_ptr         = '0;
                                n_state       = S_SRCH;
                            end
                        end
                        bil_pkg::K_MODIFY: begin
                            if (in_idx_ext >= r_cnt) begin
                                o_fin        = 1'b1;
                                o_res.status = bil_pkg::ST_RANGE;
                            end else begin
                                o_mem.rd_en   = 1'b1;
                                o_mem.rd_addr = bil_pkg::IDX_W'(i_index);
                                n_state       = S_MOD;
                            end
                        end
                        bil_pkg::K_APPEND: begin
                            o_fin = 1'b1;
                            if (r_cnt == bil_pkg::CNT_W'(bil_pkg::CAPACITY)) begin
                                o_res.status = bil_pkg::ST_FULL;
                            end else begin
                                o_mem.wr_en   = 1'b1;
                                o_mem.wr_addr = bil_pkg::IDX_W'(r_cnt);
                                o_mem.wr_data = i_value;
                                n_cnt         = r_cnt + 1'b1;
                                o_res.status  = bil_pkg::ST_OK;
                            end
                        end
                        bil_pkg::K_REMOVE: begin
                            if (in_idx_ext >= r_cnt) begin
                                o_fin        = 1'b1;
                                o_res.status = bil_pkg::ST_RANGE;
                            end else begin
                                o_mem.rd_en   = 1'b1;
                                o_mem.rd_addr = bil_pkg::IDX_W'(i_index);
                                n_state       = S_RGET;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (hit) begin
                    o_fin        = 1'b1;
                    o_res.status = bil_pkg::ST_OK;
                    o_res.found  = r_ptr;
                    n_state      = S_IDLE;
                end else if (ptr_ext + 1'b1 >= r_cnt) begin
                    o_fin        = 1'b1;
                    o_res.status = bil_pkg::ST_NOT_FOUND;
                    n_state      = S_IDLE;
                end else begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_ptr + 1'b1;
                    n_ptr         = r_ptr + 1'b1;
                end
            end
            S_MOD: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_idx;
                o_mem.wr_data = r_val;
                o_fin         = 1'b1;
                o_res.status  = bil_pkg::ST_OK;
                o_res.old     = i_rd_data;
                n_state       = S_IDLE;
            end
            S_RGET: begin
                n_old = i_rd_data;
                n_ptr = r_idx;
                if (idx_ext + 1'b1 < r_cnt) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_idx + 1'b1;
                    n_state       = S_SHIFT;
                end else begin
                    o_fin        = 1'b1;
                    o_res.status = bil_pkg::ST_OK;
                    o_res.old    = i_rd_data;
                    n_cnt        = r_cnt - 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SHIFT: begin
                // The entry read last cycle moves down one place.
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_ptr;
                o_mem.wr_data = i_rd_data;
                if (ptr_ext + bil_pkg::CNT_W'(2) < r_cnt) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_ptr + bil_pkg::IDX_W'(2);
                    n_ptr         = r_ptr + 1'b1;
                end else begin
                    o_fin        = 1'b1;
                    o_res.status = bil_pkg::ST_OK;
                    o_res.old    = r_old;
                    n_cnt        = r_cnt - 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_res.cnt = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_idx <= n_idx;
        r_val <= n_val;
        r_old <= n_old;
    end

    assign o_busy = (r_state != S_IDLE);

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= bil_pkg::CNT_W'(bil_pkg::CAPACITY))
        else $error("fill count above capacity");

    a_srch_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH || r_state == S_SHIFT) |-> ptr_ext < r_cnt)
        else $error("walk pointer beyond the filled entries");

    a_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem.rd_en && o_mem.wr_en) |-> o_mem.rd_addr != o_mem.wr_addr)
        else $error("read and write at the same entry in one cycle");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fin |-> (n_cnt == r_cnt || n_cnt == r_cnt + 1'b1 || n_cnt == r_cnt - 1'b1))
        else $error("fill count moved by more than one");

endmodule

[design/bounded_int_list_engine.sv]
// Top level of the bounded integer list engine: sequencer, entry store and result register.
//
//  Channel   Handshake            Ports
//  -------   ------------------   --------------------------------------------------
//  request   start && !busy       i_kind, i_value, i_index
//  result    o_done (one cycle)   o_status, o_found_index, o_old_value, o_count
//
// An append, an empty-list search and any request rejected as out of range or full finish in
// the cycle they are accepted. A modify reads the old entry, then writes the new one. A search
// compares one entry at a time, since the store has a single registered read port feeding one
// shared compare. A remove reads the removed entry, then moves each entry above it down one
// place per cycle through the same port. The result is registered and appears on the ports in
// the cycle after the request finishes. Reset clears the fill count and the sequencer; the
// entries are not cleared and are never read before being written. The receiver cannot stall.
module bounded_int_list_engine (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [bil_pkg::KIND_W-1:0]            i_kind,
    input  logic signed [bil_pkg::DATA_W-1:0]     i_value,
    input  logic [bil_pkg::PORT_IDX_W-1:0]        i_index,
    output logic                                  o_done,
    output logic [bil_pkg::STAT_W-1:0]            o_status,
    output logic [bil_pkg::PORT_IDX_W-1:0]        o_found_index,
    output logic signed [bil_pkg::DATA_W-1:0]     o_old_value,
    output logic [bil_pkg::PORT_CNT_W-1:0]        o_count
);

    logic                        seq_busy;
    logic                        accept;
    logic                        fin;
    bil_pkg::t_result            res;
    bil_pkg::t_mem_req           mem_req;
    logic [bil_pkg::DATA_W-1:0]  rd_data;

    logic                        r_done;
    bil_pkg::t_result            r_res;

    // A request is taken only while the sequencer is idle.
    assign accept = start && !seq_busy;

    bil_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_kind    (i_kind),
        .i_value   (i_value),
        .i_index   (i_index),
        .i_rd_data (rd_data),
        .o_busy    (seq_busy),
        .o_mem     (mem_req),
        .o_fin     (fin),
        .o_res     (res)
    );

    bil_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // The result register keeps each result until the next; o_done strobes once per result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_res <= res;
        end
    end

    assign busy          = seq_busy;
    assign o_done        = r_done;
    assign o_status      = r_res.status;
    assign o_found_index = bil_pkg::PORT_IDX_W'(r_res.found);
    assign o_old_value   = r_res.old;
    assign o_count       = bil_pkg::PORT_CNT_W'(r_res.cnt);

    a_found_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == bil_pkg::ST_OK || o_found_index == '0))
        else $error("found index set on a failed request");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == bil_pkg::ST_FULL) |->
            o_count == bil_pkg::PORT_CNT_W'(bil_pkg::CAPACITY))
        else $error("list reported full below capacity");

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept || seq_busy))
        else $error("result without a request in progress");

endmodule

[verif/tb_bounded_int_list_engine.sv]
// Self-checking testbench for the bounded integer list engine, with its own list model.
`timescale 1ns / 100ps

module tb_bounded_int_list_engine;

    // The run ends here even if the block hangs, with a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 550;
    localparam int PRINT_CAP     = 40;

    // One request as the stimulus builds it. The gap is the number of idle cycles before the
    // request goes out. The hold flag makes the sender wait until every result is back.
    typedef struct {
        bil_pkg::t_kind                    kind;
        logic signed [bil_pkg::DATA_W-1:0] value;
        logic [bil_pkg::PORT_IDX_W-1:0]    index;
        int                                gap;
        bit                                hold;
    } t_list_req;

    // One result as the block reports it.
    typedef struct {
        bil_pkg::t_status                  status;
        logic [bil_pkg::PORT_IDX_W-1:0]    found;
        logic signed [bil_pkg::DATA_W-1:0] old;
        logic [bil_pkg::PORT_CNT_W-1:0]    count;
    } t_list_result;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  start = 1'b0;
    logic                                  busy;
    logic [bil_pkg::KIND_W-1:0]            i_kind = bil_pkg::K_SEARCH;
    logic signed [bil_pkg::DATA_W-1:0]     i_value = '0;
    logic [bil_pkg::PORT_IDX_W-1:0]        i_index = '0;
    logic                                  o_done;
    logic [bil_pkg::STAT_W-1:0]            o_status;
    logic [bil_pkg::PORT_IDX_W-1:0]        o_found_index;
    logic signed [bil_pkg::DATA_W-1:0]     o_old_value;
    logic [bil_pkg::PORT_CNT_W-1:0]        o_count;

    bounded_int_list_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .i_index       (i_index),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_old_value   (o_old_value),
        .o_count       (o_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Requests not yet sent, and results owed by the block in the order they will come.
    t_list_req    pending_q[$];
    t_list_result expected_q[$];

    // The testbench's own copy of the list, advanced once per accepted request.
    logic signed [bil_pkg::DATA_W-1:0] list_words [bil_pkg::CAPACITY];
    int                                list_len = 0;

    // The stimulus keeps a count of its own so it can aim indexes at live entries.
    int gen_len = 0;

    int error_count   = 0;
    int checked_count = 0;
    int cycle_count   = 0;
    int drain_count   = 0;
    int kind_sent     [4] = '{0, 0, 0, 0};
    int status_seen   [4] = '{0, 0, 0, 0};

    // Applies one request to the model list and returns what the block should report.
    // Search takes the lowest matching position; modify and remove reject an index at or
    // past the count, and append rejects a full list. Rejected requests leave the list as is.
    function automatic t_list_result apply_request(input t_list_req req);
        t_list_result res;
        int           pos;
        res.status = bil_pkg::ST_OK;
        res.found  = '0;
        res.old    = '0;
        case (req.kind)
            bil_pkg::K_SEARCH: begin
                res.status = bil_pkg::ST_NOT_FOUND;
                for (pos = 0; pos < list_len; pos++) begin
                    if (res.status == bil_pkg::ST_NOT_FOUND && list_words[pos] == req.value) begin
                        res.status = bil_pkg::ST_OK;
                        res.found  = pos[bil_pkg::PORT_IDX_W-1:0];
                    end
                end
            end
            bil_pkg::K_MODIFY: begin
                if (int'(req.index) >= list_len) begin
                    res.status = bil_pkg::ST_RANGE;
                end else begin
                    res.old = list_words[req.index];
                    list_words[req.index] = req.value;
                end
            end
            bil_pkg::K_APPEND: begin
                if (list_len >= bil_pkg::CAPACITY) begin
                    res.status = bil_pkg::ST_FULL;
                end else begin
                    list_words[list_len] = req.value;
                    list_len++;
                end
            end
            default: begin
                if (int'(req.index) >= list_len) begin
                    res.status = bil_pkg::ST_RANGE;
                end else begin
                    res.old = list_words[req.index];
                    for (pos = int'(req.index); pos + 1 < list_len; pos++) begin
                        list_words[pos] = list_words[pos + 1];
                    end
                    list_len--;
                end
            end
        endcase
        res.count = list_len[bil_pkg::PORT_CNT_W-1:0];
        return res;
    endfunction

    // Counts a mismatch and prints one line for it, up to a cap so a broken block
    // does not flood the log.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= PRINT_CAP) begin
            $display("[%0t] result %0d: %s is %0h, expected %0h",
                     $time, checked_count, what, got, want);
        end
    endtask

    // Adds one request to the pending queue and keeps the stimulus count in step.
    task automatic queue_request(input bil_pkg::t_kind kind,
                                 input logic signed [bil_pkg::DATA_W-1:0] value,
                                 input int index, input int gap, input bit hold);
        t_list_req req;
        req.kind  = kind;
        req.value = value;
        req.index = index[bil_pkg::PORT_IDX_W-1:0];
        req.gap   = gap;
        req.hold  = hold;
        pending_q.push_back(req);
        if (kind == bil_pkg::K_APPEND && gen_len < bil_pkg::CAPACITY) begin
            gen_len++;
        end else if (kind == bil_pkg::K_REMOVE && index < gen_len) begin
            gen_len--;
        end
    endtask

    // Values are drawn often from a small pool so that searches hit and duplicates occur,
    // with the two extremes and fully random words mixed in.
    function automatic logic signed [bil_pkg::DATA_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            case ($urandom_range(0, 5))
                0: return 32'sh0000_0000;
                1: return -32'sd1;
                2: return 32'sh0000_0001;
                3: return 32'sh1234_5678;
                4: return 32'shDEAD_BEEF;
                default: return 32'sh8000_0000;
            endcase
        end else if (r < 55) begin
            return r[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        end
        return $urandom();
    endfunction

    // Idle gaps before a request: mostly none or short, now and then long.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sender. A request is taken at the edge where start is high and busy is low; the model
    // is advanced right there so expectations line up with the order of acceptance. The next
    // request is raised only after its gap, and a held request waits for all results first.
    // start gets a single assignment per edge, so it stays high across back-to-back requests.
    t_list_req cur_req = '{kind: bil_pkg::K_SEARCH, value: '0, index: '0, gap: 0, hold: 1'b0};
    bit        issuing = 1'b0;
    int        gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            issuing  = 1'b0;
            gap_left = 0;
            start   <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_q.push_back(apply_request(cur_req));
                kind_sent[cur_req.kind]++;
                issuing = 1'b0;
                if (pending_q.size() != 0) begin
                    gap_left = pending_q[0].gap;
                end
            end
            if (!issuing) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_q.size() != 0 &&
                             (!pending_q[0].hold || expected_q.size() == 0)) begin
                    if (pending_q[0].hold) begin
                        drain_count++;
                    end
                    cur_req = pending_q.pop_front();
                    issuing = 1'b1;
                end
            end
            start   <= issuing;
            i_kind  <= cur_req.kind;
            i_value <= cur_req.value;
            i_index <= cur_req.index;
        end
    end

    // Receiver. The block cannot be held off, so every strobed result is taken and compared
    // field by field with the oldest expectation.
    always @(posedge i_clk) begin : result_monitor
        t_list_result want;
        if (i_rst_n && o_done) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with no request outstanding, status",
                                64'(o_status), '0);
            end else begin
                want = expected_q.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                end
                if (o_found_index !== want.found) begin
                    report_mismatch("found index", 64'(o_found_index), 64'(want.found));
                end
                if (o_old_value !== want.old) begin
                    report_mismatch("old value", 64'($unsigned(o_old_value)),
                                    64'($unsigned(want.old)));
                end
                if (o_count !== want.count) begin
                    report_mismatch("count", 64'(o_count), 64'(want.count));
                end
                status_seen[want.status]++;
                checked_count++;
            end
        end
    end

    // Watchdog: a run that stalls is a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        int             n;
        int             r;
        int             idx;
        int             gap;
        bit             grow;
        bit             calm;
        bil_pkg::t_kind kind;

        // Directed part. Empty list first: every operation but append is rejected or misses.
        queue_request(bil_pkg::K_SEARCH, 32'sh0000_0000, 0, 0, 1'b0);
        queue_request(bil_pkg::K_REMOVE, 32'sh0000_0000, 0, 0, 1'b0);
        queue_request(bil_pkg::K_MODIFY, 32'sh0000_0000, 15, 0, 1'b0);

        // Fill to capacity with the extremes, a duplicate at positions one and four, and
        // distinct filler words after that.
        queue_request(bil_pkg::K_APPEND, 32'sh8000_0000, 15, 0, 1'b0);
        queue_request(bil_pkg::K_APPEND, 32'sh7FFF_FFFF, 0, 0, 1'b0);
        queue_request(bil_pkg::K_APPEND, 32'sh0000_0000, 0, 0, 1'b0);
        queue_request(bil_pkg::K_APPEND, -32'sd1, 0, 0, 1'b0);
        queue_request(bil_pkg::K_APPEND, 32'sh7FFF_FFFF, 0, 0, 1'b0);
        for (n = 5; n < bil_pkg::CAPACITY; n++) begin
            queue_request(bil_pkg::K_APPEND, 32'sh1000_0000 + n, n, 0, 1'b0);
        end

        // A full list refuses an append; the duplicate search must report the lower position.
        queue_request(bil_pkg::K_APPEND, 32'sh0BAD_0BAD, 0, 0, 1'b0);
        queue_request(bil_pkg::K_SEARCH, 32'sh7FFF_FFFF, 0, 0, 1'b0);
        queue_request(bil_pkg::K_SEARCH, 32'sh2468_ACE0, 0, 0, 1'b0);

        // Touch the top position, then remove from the front so every entry shifts, then the
        // last entry, then an index just past the new count.
        queue_request(bil_pkg::K_MODIFY, 32'sh5555_5555, 15, 0, 1'b0);
        queue_request(bil_pkg::K_SEARCH, 32'sh5555_5555, 0, 0, 1'b0);
        queue_request(bil_pkg::K_REMOVE, 32'sh0000_0000, 0, 0, 1'b0);
        queue_request(bil_pkg::K_REMOVE, 32'sh0000_0000, 14, 0, 1'b0);
        queue_request(bil_pkg::K_MODIFY, 32'shAAAA_AAAA, 14, 0, 1'b0);

        // Random part. The list swings between growing and shrinking so it regularly runs
        // full and empty. Most requests aim at live entries; a slice of them is pure noise.
        grow = 1'b0;
        calm = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (gen_len == bil_pkg::CAPACITY && $urandom_range(0, 3) == 0) grow = 1'b0;
            if (gen_len == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
            if ($urandom_range(0, 49) == 0) grow = !grow;
            if (n % 60 == 0) calm = ($urandom_range(0, 2) == 0);

            r = $urandom_range(0, 99);
            if (r < 25) kind = bil_pkg::K_SEARCH;
            else if (r < 40) kind = bil_pkg::K_MODIFY;
            else if (r < 85) kind = grow ? bil_pkg::K_APPEND : bil_pkg::K_REMOVE;
            else kind = grow ? bil_pkg::K_REMOVE : bil_pkg::K_APPEND;

            if (gen_len > 0 && $urandom_range(0, 99) < 85) begin
                idx = $urandom_range(0, gen_len - 1);
            end else begin
                idx = $urandom_range(0, 15);
            end

            if ($urandom_range(0, 99) < 8) begin
                kind = bil_pkg::t_kind'($urandom_range(0, 3));
                idx  = $urandom_range(0, 15);
            end

            gap = calm ? 0 : pick_gap();
            queue_request(kind, pick_value(), idx, gap, (n % 90 == 45));
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request has gone out and every result has come back, then leave
        // room for a stray strobe before the verdict.
        do begin
            @(negedge i_clk);
        end while (pending_q.size() != 0 || start || expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Checked %0d results: %0d searches, %0d modifies, %0d appends, %0d removes.",
                 checked_count, kind_sent[bil_pkg::K_SEARCH], kind_sent[bil_pkg::K_MODIFY],
                 kind_sent[bil_pkg::K_APPEND], kind_sent[bil_pkg::K_REMOVE]);
        $display("Outcomes: %0d ok, %0d not found, %0d out of range, %0d full; %0d drains.",
                 status_seen[bil_pkg::ST_OK], status_seen[bil_pkg::ST_NOT_FOUND],
                 status_seen[bil_pkg::ST_RANGE], status_seen[bil_pkg::ST_FULL], drain_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
